// File: rtl/frmd_pkg.sv
// Shared widths, codes and controller/datapath handshake types for the frame rate monitor.
package frmd_pkg;

  localparam int unsigned TIME_W     = 48;
  localparam int unsigned DUS_W      = 24;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned TOT_W      = 34;
  localparam int unsigned ACC_W      = 11;
  localparam int unsigned FPS_W      = 8;
  localparam int unsigned OVW_W      = 32;
  localparam int unsigned OC_W       = 3;
  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [DUS_W-1:0] DUS_MAX = '1;

  localparam logic OP_DECODE  = 1'b0;
  localparam logic OP_DISPLAY = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_PACE_EN    = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_FPS = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NEGOT_FPS  = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE     = 8'd3;

  typedef enum logic [OC_W-1:0] {
    OC_NO_PIC     = 3'd0,
    OC_READY      = 3'd1,
    OC_OVERWROTE  = 3'd2,
    OC_INACTIVE   = 3'd3,
    OC_NONE_READY = 3'd4,
    OC_DROPPED    = 3'd5,
    OC_SHOWN      = 3'd6
  } outcome_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic store_avg;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } dp_stat_t;

endpackage

// File: rtl/frmd_ifs.sv
// Channel interfaces: event input, result output and configuration write.
interface frmd_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [frmd_pkg::TIME_W-1:0]  time_us;
  logic [frmd_pkg::DUS_W-1:0]   decode_us;
  logic                         decode_ok;

  modport source (output valid, opcode, time_us, decode_us, decode_ok, input ready);
  modport sink   (input valid, opcode, time_us, decode_us, decode_ok, output ready);
endinterface

interface frmd_out_if;
  logic                         valid;
  logic                         ready;
  logic [frmd_pkg::OC_W-1:0]    outcome;
  logic [frmd_pkg::CNT_W-1:0]   incoming_fps;
  logic [frmd_pkg::CNT_W-1:0]   shown_fps;
  logic [frmd_pkg::DUS_W-1:0]   dec_avg_us;
  logic [frmd_pkg::DUS_W-1:0]   dec_peak_us;
  logic [frmd_pkg::OVW_W-1:0]   overwrite_total;

  modport source (output valid, outcome, incoming_fps, shown_fps, dec_avg_us,
                  dec_peak_us, overwrite_total, input ready);
  modport sink   (input valid, outcome, incoming_fps, shown_fps, dec_avg_us,
                  dec_peak_us, overwrite_total, output ready);
endinterface

interface frmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [frmd_pkg::CFG_ADDR_W-1:0] addr;
  logic [frmd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: rtl/frmd_div.sv
// Restoring divider, one quotient bit per cycle, for the average decode time.
module frmd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [frmd_pkg::TOT_W-1:0]  dividend,
  input  logic [frmd_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [frmd_pkg::TOT_W-1:0]  quotient
);
  import frmd_pkg::*;

  localparam int unsigned STEPS  = TOT_W;
  localparam int unsigned STEP_W = $clog2(STEPS + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dsr_r, dsr_nxt;
  logic [TOT_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              ge;

  always_comb begin
    shifted  = {rem_r, quo_r[TOT_W-1]};
    diff     = shifted - {1'b0, dsr_r};
    ge       = shifted >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(STEPS);
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_nxt = {quo_r[TOT_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/frmd_dp.sv
// Datapath: statistics windows, ready flag, pacing accumulator and result register.
module frmd_dp #(
  parameter int unsigned WINDOW_US = 1000000
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  frmd_pkg::dp_cmd_t                cmd,
  output frmd_pkg::dp_stat_t               stat,
  input  logic                             cfg_wr,
  input  logic [frmd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [frmd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_opcode,
  input  logic [frmd_pkg::TIME_W-1:0]      in_time_us,
  input  logic [frmd_pkg::DUS_W-1:0]       in_decode_us,
  input  logic                             in_decode_ok,
  output logic [frmd_pkg::OC_W-1:0]        out_outcome,
  output logic [frmd_pkg::CNT_W-1:0]       out_incoming_fps,
  output logic [frmd_pkg::CNT_W-1:0]       out_shown_fps,
  output logic [frmd_pkg::DUS_W-1:0]       out_dec_avg_us,
  output logic [frmd_pkg::DUS_W-1:0]       out_dec_peak_us,
  output logic [frmd_pkg::OVW_W-1:0]       out_overwrite_total
);
  import frmd_pkg::*;

  localparam logic [TIME_W-1:0] WINDOW = TIME_W'(WINDOW_US);

  // Latched item.
  logic              op_r;
  logic [TIME_W-1:0] time_r;
  logic [DUS_W-1:0]  dus_r;
  logic              ok_r;

  // Configuration.
  logic             pace_en_r, pace_en_nxt;
  logic [FPS_W-1:0] target_r, target_nxt;
  logic [FPS_W-1:0] negot_r, negot_nxt;
  logic             active_r, active_nxt;

  // Statistics state.
  logic [TIME_W-1:0] in_start_r, in_start_nxt;
  logic [CNT_W-1:0]  in_cnt_r, in_cnt_nxt;
  logic [CNT_W-1:0]  meas_fps_r, meas_fps_nxt;
  logic [TOT_W-1:0]  dec_total_r, dec_total_nxt;
  logic [DUS_W-1:0]  dec_max_r, dec_max_nxt;
  logic [CNT_W-1:0]  dec_cnt_r, dec_cnt_nxt;
  logic [DUS_W-1:0]  avg_pub_r, avg_pub_nxt;
  logic [DUS_W-1:0]  max_pub_r, max_pub_nxt;
  logic              ready_flag_r, ready_flag_nxt;
  logic [ACC_W-1:0]  accum_r, accum_nxt;
  logic [OVW_W-1:0]  ovw_r, ovw_nxt;
  logic [TIME_W-1:0] disp_start_r, disp_start_nxt;
  logic [CNT_W-1:0]  disp_cnt_r, disp_cnt_nxt;
  logic [CNT_W-1:0]  disp_pub_r, disp_pub_nxt;
  outcome_t          outcome_r, outcome_nxt;

  // Step logic.
  logic              is_decode;
  logic              picture;
  logic              dec_sat;
  logic [TOT_W-1:0]  tot_upd;
  logic [CNT_W-1:0]  cnt_upd;
  logic [DUS_W-1:0]  max_upd;
  logic [TIME_W-1:0] in_start_eff;
  logic [CNT_W-1:0]  in_cnt_inc;
  logic              in_pub;
  logic [TIME_W-1:0] disp_start_eff;
  logic [CNT_W-1:0]  disp_cnt_inc;
  logic              disp_pub;
  logic [CNT_W-1:0]  source;
  logic              pace_on;
  logic [ACC_W-1:0]  acc_sum;
  logic              drop;
  logic              div_done;
  logic [TOT_W-1:0]  quotient;

  always_comb begin
    is_decode = (op_r == OP_DECODE);
    picture   = ok_r && active_r;
    dec_sat   = (dec_cnt_r == CNT_MAX);
    tot_upd   = dec_sat ? dec_total_r : dec_total_r + TOT_W'(dus_r);
    cnt_upd   = dec_sat ? dec_cnt_r : dec_cnt_r + 1'b1;
    max_upd   = (dus_r > dec_max_r) ? dus_r : dec_max_r;

    in_start_eff = (in_start_r == '0) ? time_r : in_start_r;
    in_cnt_inc   = (in_cnt_r == CNT_MAX) ? in_cnt_r : in_cnt_r + 1'b1;
    in_pub       = (time_r - in_start_eff) >= WINDOW;

    disp_start_eff = (disp_start_r == '0) ? time_r : disp_start_r;
    disp_cnt_inc   = (disp_cnt_r == CNT_MAX) ? disp_cnt_r : disp_cnt_r + 1'b1;
    disp_pub       = (time_r - disp_start_eff) >= WINDOW;

    // The measured rate takes over from the negotiated one once it exists.
    source  = (meas_fps_r != '0) ? meas_fps_r : CNT_W'(negot_r);
    pace_on = pace_en_r && (target_r != '0) && (source != '0) &&
              (CNT_W'(target_r) < source);
    acc_sum = accum_r + ACC_W'(target_r);
    drop    = acc_sum < ACC_W'(source);
  end

  assign stat.need_div = is_decode && picture && in_pub;
  assign stat.div_done = div_done;

  frmd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.exec && stat.need_div),
    .dividend (tot_upd),
    .divisor  (cnt_upd),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    pace_en_nxt    = pace_en_r;
    target_nxt     = target_r;
    negot_nxt      = negot_r;
    active_nxt     = active_r;
    in_start_nxt   = in_start_r;
    in_cnt_nxt     = in_cnt_r;
    meas_fps_nxt   = meas_fps_r;
    dec_total_nxt  = dec_total_r;
    dec_max_nxt    = dec_max_r;
    dec_cnt_nxt    = dec_cnt_r;
    avg_pub_nxt    = avg_pub_r;
    max_pub_nxt    = max_pub_r;
    ready_flag_nxt = ready_flag_r;
    accum_nxt      = accum_r;
    ovw_nxt        = ovw_r;
    disp_start_nxt = disp_start_r;
    disp_cnt_nxt   = disp_cnt_r;
    disp_pub_nxt   = disp_pub_r;
    outcome_nxt    = outcome_r;

    if (cfg_wr) begin
      unique case (cfg_addr)
        REG_PACE_EN:    pace_en_nxt = cfg_data[0];
        REG_TARGET_FPS: target_nxt  = cfg_data;
        REG_NEGOT_FPS:  negot_nxt   = cfg_data;
        REG_ACTIVE: begin
          active_nxt = cfg_data[0];
          if (cfg_data[0] && !active_r) begin
            disp_pub_nxt   = '0;
            disp_cnt_nxt   = '0;
            disp_start_nxt = '0;
            ready_flag_nxt = 1'b0;
          end else if (!cfg_data[0] && active_r) begin
            ready_flag_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd.exec) begin
      if (is_decode) begin
        dec_total_nxt = tot_upd;
        dec_cnt_nxt   = cnt_upd;
        dec_max_nxt   = max_upd;
        if (!ok_r) begin
          outcome_nxt = OC_NO_PIC;
        end else if (!active_r) begin
          outcome_nxt = OC_INACTIVE;
        end else begin
          if (in_pub) begin
            // Window closes: publish and restart; the average follows from the divider.
            meas_fps_nxt  = in_cnt_inc;
            max_pub_nxt   = max_upd;
            dec_total_nxt = '0;
            dec_max_nxt   = '0;
            dec_cnt_nxt   = '0;
            in_cnt_nxt    = '0;
            in_start_nxt  = time_r;
          end else begin
            in_cnt_nxt   = in_cnt_inc;
            in_start_nxt = in_start_eff;
          end
          if (ready_flag_r) begin
            ovw_nxt     = ovw_r + 1'b1;
            outcome_nxt = OC_OVERWROTE;
          end else begin
            outcome_nxt = OC_READY;
          end
          ready_flag_nxt = 1'b1;
        end
      end else if (!ready_flag_r) begin
        outcome_nxt = OC_NONE_READY;
      end else begin
        ready_flag_nxt = 1'b0;
        if (pace_on) begin
          accum_nxt = drop ? acc_sum : acc_sum - ACC_W'(source);
        end
        if (pace_on && drop) begin
          outcome_nxt = OC_DROPPED;
        end else begin
          outcome_nxt = OC_SHOWN;
          if (disp_pub) begin
            disp_pub_nxt   = disp_cnt_inc;
            disp_cnt_nxt   = '0;
            disp_start_nxt = time_r;
          end else begin
            disp_cnt_nxt   = disp_cnt_inc;
            disp_start_nxt = disp_start_eff;
          end
        end
      end
    end else if (cmd.store_avg) begin
      avg_pub_nxt = (quotient > TOT_W'(DUS_MAX)) ? DUS_MAX : quotient[DUS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pace_en_r    <= 1'b0;
      target_r     <= '0;
      negot_r      <= '0;
      active_r     <= 1'b0;
      in_start_r   <= '0;
      in_cnt_r     <= '0;
      meas_fps_r   <= '0;
      dec_total_r  <= '0;
      dec_max_r    <= '0;
      dec_cnt_r    <= '0;
      avg_pub_r    <= '0;
      max_pub_r    <= '0;
      ready_flag_r <= 1'b0;
      accum_r      <= '0;
      ovw_r        <= '0;
      disp_start_r <= '0;
      disp_cnt_r   <= '0;
      disp_pub_r   <= '0;
      outcome_r    <= OC_NO_PIC;
    end else begin
      pace_en_r    <= pace_en_nxt;
      target_r     <= target_nxt;
      negot_r      <= negot_nxt;
      active_r     <= active_nxt;
      in_start_r   <= in_start_nxt;
      in_cnt_r     <= in_cnt_nxt;
      meas_fps_r   <= meas_fps_nxt;
      dec_total_r  <= dec_total_nxt;
      dec_max_r    <= dec_max_nxt;
      dec_cnt_r    <= dec_cnt_nxt;
      avg_pub_r    <= avg_pub_nxt;
      max_pub_r    <= max_pub_nxt;
      ready_flag_r <= ready_flag_nxt;
      accum_r      <= accum_nxt;
      ovw_r        <= ovw_nxt;
      disp_start_r <= disp_start_nxt;
      disp_cnt_r   <= disp_cnt_nxt;
      disp_pub_r   <= disp_pub_nxt;
      outcome_r    <= outcome_nxt;
    end
  end

  // Item latch and result register carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_opcode;
      time_r <= in_time_us;
      dus_r  <= in_decode_us;
      ok_r   <= in_decode_ok;
    end
    if (cmd.load_out) begin
      out_outcome         <= outcome_r;
      out_incoming_fps    <= meas_fps_r;
      out_shown_fps       <= disp_pub_r;
      out_dec_avg_us      <= avg_pub_r;
      out_dec_peak_us     <= max_pub_r;
      out_overwrite_total <= ovw_r;
    end
  end

endmodule

// File: rtl/frmd_ctrl.sv
// Controller: sequences accept, step, optional divide and result hand-off.
module frmd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output frmd_pkg::dp_cmd_t   cmd,
  input  frmd_pkg::dp_stat_t  stat
);
  import frmd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_div ? S_DIV : S_PUSH;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.store_avg = 1'b1;
          state_nxt     = S_PUSH;
        end
      end
      S_PUSH: begin
        // The result register is free once its previous transfer completes.
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/frame_rate_monitor_decimator_top.sv
// Frame rate monitor and decimator top level.
// Usage: events arrive on in_ch (decode completion or display request, each with a
// microsecond timestamp); every event yields exactly one result on out_ch with its
// outcome and the published incoming fps, displayed fps, average and maximum decode
// time and the overwrite total. Registers are written through cfg_ch, which is always
// ready; write them only while no event is in flight.
// Timing: one event is processed at a time. A result is loaded after the step state,
// and also after the divide state when a decode closes the one-second window, because
// the average decode time comes from a 34-step bit-serial divider. The next event is
// taken in the cycle after the result is loaded; no new event is accepted before then.
// Reset clears all counters, published values, the ready flag and the registers.
// A stalled receiver holds the result in the output register; the block still
// accepts one more event and holds its result until the previous transfer completes.
module frame_rate_monitor_decimator_top #(
  parameter int unsigned WINDOW_US = 1000000
) (
  input  logic       clk,
  input  logic       rst_n,
  frmd_in_if.sink    in_ch,
  frmd_out_if.source out_ch,
  frmd_cfg_if.sink   cfg_ch
);
  import frmd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  frmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  frmd_dp #(
    .WINDOW_US (WINDOW_US)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_wr              (cfg_ch.valid && cfg_ch.ready),
    .cfg_addr            (cfg_ch.addr),
    .cfg_data            (cfg_ch.data),
    .in_opcode           (in_ch.opcode),
    .in_time_us          (in_ch.time_us),
    .in_decode_us        (in_ch.decode_us),
    .in_decode_ok        (in_ch.decode_ok),
    .out_outcome         (out_ch.outcome),
    .out_incoming_fps    (out_ch.incoming_fps),
    .out_shown_fps       (out_ch.shown_fps),
    .out_dec_avg_us      (out_ch.dec_avg_us),
    .out_dec_peak_us     (out_ch.dec_peak_us),
    .out_overwrite_total (out_ch.overwrite_total)
  );

endmodule

// File: rtl/frmd_chk.sv
// Port-level checker for the frame rate monitor, bound to the top level.
module frmd_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [frmd_pkg::OC_W-1:0]   out_outcome,
  input logic [frmd_pkg::OVW_W-1:0]  out_overwrite_total
);
  import frmd_pkg::*;

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_outcome) &&
                                $stable(out_overwrite_total))
    else $error("result changed while stalled");

  // Events are processed one at a time, so input is closed right after a transfer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an event is in flight");

  // A result needs at least the step cycle after its input transfer.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind frame_rate_monitor_decimator_top frmd_chk u_frmd_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_outcome         (out_ch.outcome),
  .out_overwrite_total (out_ch.overwrite_total)
);
